// File: design/gbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbm_pkg
// shared types and constants of the gated bipartite matcher
// ----------------------------------------------------------------------------
package gbm_pkg;

    localparam int MaxDets   = 32;
    localparam int MaxTracks = 32;
    localparam int DetW      = $clog2(MaxDets);
    localparam int TrackW    = $clog2(MaxTracks);
    localparam int DetCntW   = $clog2(MaxDets + 1);
    localparam int TrackCntW = $clog2(MaxTracks + 1);
    localparam int SpW       = $clog2(MaxDets + 1);

    localparam logic [15:0] ThresholdReset = 16'd100;

    typedef struct packed {
        logic [4:0]  det_index;
        logic [4:0]  track_index;
        logic [15:0] distance;
        logic [5:0]  det_count;
        logic [5:0]  track_count;
        logic        last_entry;
    } in_item_t;

    typedef struct packed {
        logic [4:0] result_track;
        logic       has_owner;
        logic [4:0] owner_det;
        logic [5:0] match_total;
        logic       last_result;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;        // store edge bit of the accepted entry
        logic start;       // latch counts, clear owners
        logic root_push;   // push the next root detection
        logic step;        // one search step on top frame
        logic emit_load;   // load output register with current track
        logic emit_next;   // advance emit track
    } gbm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic roots_done;  // all detections tried
        logic stack_empty;
        logic emit_done;   // emit track reached track count
        logic no_tracks;
    } gbm_sts_t;

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_ROOT  = 4'b0010,
        ST_WALK  = 4'b0100,
        ST_EMIT  = 4'b1000
    } gbm_state_t;

endpackage

// File: design/gbm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbm_in_if / gbm_out_if
// valid/ready channels for distance entries and per-track results
// ----------------------------------------------------------------------------
interface gbm_in_if;
    logic              valid;
    logic              ready;
    gbm_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gbm_out_if;
    logic               valid;
    logic               ready;
    gbm_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/gbm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbm_ctrl
// sequences load, matching walk and result emission
// ----------------------------------------------------------------------------
module gbm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_last,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  gbm_pkg::gbm_sts_t sts,
    output gbm_pkg::gbm_cmd_t cmd
);

    gbm_pkg::gbm_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic can_load;

    assign in_ready  = (state_reg == gbm_pkg::ST_LOAD);
    assign out_valid = out_valid_reg;
    assign can_load  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            gbm_pkg::ST_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        cmd.start  = 1'b1;
                        state_next = gbm_pkg::ST_ROOT;
                    end
                end
            end
            gbm_pkg::ST_ROOT:
            begin
                if (sts.roots_done)
                    state_next = sts.no_tracks ? gbm_pkg::ST_LOAD : gbm_pkg::ST_EMIT;
                else
                begin
                    cmd.root_push = 1'b1;
                    state_next    = gbm_pkg::ST_WALK;
                end
            end
            gbm_pkg::ST_WALK:
            begin
                if (sts.stack_empty)
                    state_next = gbm_pkg::ST_ROOT;
                else
                    cmd.step = 1'b1;
            end
            gbm_pkg::ST_EMIT:
            begin
                if (sts.emit_done)
                begin
                    if (!out_valid_reg || out_ready)
                        state_next = gbm_pkg::ST_LOAD;
                end
                else if (can_load)
                begin
                    cmd.emit_load  = 1'b1;
                    cmd.emit_next  = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
                state_next = gbm_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gbm_pkg::ST_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != gbm_pkg::ST_LOAD) |-> !in_ready)
        else $error("input ready while matching");
    a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == gbm_pkg::ST_EMIT))
        else $error("result raised outside emit");
    a_start_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (state_reg == gbm_pkg::ST_ROOT))
        else $error("start did not enter matching");

endmodule

// File: design/gbm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbm_dp
// edge matrix, owner table, search stack and result register
// ----------------------------------------------------------------------------
module gbm_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        match_threshold,
    input  gbm_pkg::in_item_t  in_data,
    input  gbm_pkg::gbm_cmd_t  cmd,
    output gbm_pkg::gbm_sts_t  sts,
    output gbm_pkg::out_item_t out_data
);

    localparam int Nd = gbm_pkg::MaxDets;
    localparam int Nt = gbm_pkg::MaxTracks;
    localparam int Dw = gbm_pkg::DetW;
    localparam int Tw = gbm_pkg::TrackW;

    logic [Nt-1:0] edge_rows_reg [Nd];
    logic [Dw-1:0] track_owner_reg [Nt];
    logic [Nt-1:0] owner_valid_reg;
    logic [Nt-1:0] visited_reg;
    logic [Dw-1:0] stk_det_reg [Nd];
    logic [Tw-1:0] stk_pos_reg [Nd];
    logic [gbm_pkg::SpW-1:0] sp_reg;
    logic          child_ok_reg;  // previous popped frame succeeded
    logic          child_fail_reg;
    logic [gbm_pkg::DetCntW-1:0]   nd_reg, root_reg, total_reg;
    logic [gbm_pkg::TrackCntW-1:0] nt_reg, emit_reg;
    gbm_pkg::out_item_t out_reg;

    logic [gbm_pkg::DetCntW-1:0]   nd_sat;
    logic [gbm_pkg::TrackCntW-1:0] nt_sat;
    logic [Dw-1:0]  top_det;
    logic [Tw-1:0]  top_pos;
    logic [Dw-1:0]  top_idx;
    logic [Nt-1:0]  cand;
    logic           found;
    logic [Tw-1:0]  found_t;
    logic [Tw-1:0]  start_t;
    logic [Tw-1:0]  emit_t;

    assign nd_sat = (in_data.det_count > 6'(Nd)) ? gbm_pkg::DetCntW'(Nd)
                                                 : gbm_pkg::DetCntW'(in_data.det_count);
    assign nt_sat = (in_data.track_count > 6'(Nt)) ? gbm_pkg::TrackCntW'(Nt)
                                                   : gbm_pkg::TrackCntW'(in_data.track_count);

    assign top_idx = Dw'(sp_reg - 1'b1);
    assign top_det = stk_det_reg[top_idx];
    assign top_pos = stk_pos_reg[top_idx];
    assign start_t = child_fail_reg ? Tw'(top_pos + 1'b1) : top_pos;

    // priority pick of the lowest unvisited edge at or above the cursor
    always_comb
    begin
        found   = 1'b0;
        found_t = '0;
        for (int i = 0; i < Nt; i++)
        begin
            cand[i] = edge_rows_reg[top_det][i] && !visited_reg[i]
                      && (i < int'(nt_reg)) && (i >= int'(start_t))
                      && !(child_fail_reg && top_pos == Tw'(Nt - 1));
        end
        for (int i = Nt - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                found   = 1'b1;
                found_t = Tw'(i);
            end
        end
    end

    assign emit_t = Tw'(emit_reg);
    assign sts.roots_done  = (root_reg == nd_reg);
    assign sts.stack_empty = (sp_reg == '0);
    assign sts.emit_done   = (emit_reg == nt_reg);
    assign sts.no_tracks   = (nt_reg == '0);
    assign out_data        = out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load && gbm_pkg::DetCntW'(in_data.det_index) < gbm_pkg::DetCntW'(Nd)
            && gbm_pkg::TrackCntW'(in_data.track_index) < gbm_pkg::TrackCntW'(Nt))
            edge_rows_reg[in_data.det_index][in_data.track_index]
                <= (in_data.distance < match_threshold);
        if (cmd.root_push)
        begin
            stk_det_reg[0] <= Dw'(root_reg);
            stk_pos_reg[0] <= '0;
        end
        if (cmd.step && !child_ok_reg)
        begin
            if (found)
            begin
                stk_pos_reg[top_idx] <= found_t;
                if (owner_valid_reg[found_t] && sp_reg < gbm_pkg::SpW'(Nd))
                begin
                    stk_det_reg[Dw'(sp_reg)] <= track_owner_reg[found_t];
                    stk_pos_reg[Dw'(sp_reg)] <= '0;
                end
            end
        end
        if (cmd.step)
        begin
            if (child_ok_reg)
                track_owner_reg[top_pos] <= top_det;
            else if (found && !owner_valid_reg[found_t])
                track_owner_reg[found_t] <= top_det;
        end
        if (cmd.emit_load)
        begin
            out_reg.result_track <= emit_t;
            out_reg.has_owner    <= owner_valid_reg[emit_t];
            out_reg.owner_det    <= owner_valid_reg[emit_t] ? track_owner_reg[emit_t] : '0;
            out_reg.match_total  <= 6'(total_reg);
            out_reg.last_result  <= (emit_reg + 1'b1 == nt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_valid_reg <= '0;
            visited_reg     <= '0;
            sp_reg          <= '0;
            child_ok_reg    <= 1'b0;
            child_fail_reg  <= 1'b0;
            nd_reg          <= '0;
            nt_reg          <= '0;
            root_reg        <= '0;
            total_reg       <= '0;
            emit_reg        <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                nd_reg          <= nd_sat;
                nt_reg          <= nt_sat;
                root_reg        <= '0;
                total_reg       <= '0;
                emit_reg        <= '0;
                owner_valid_reg <= '0;
            end
            if (cmd.root_push)
            begin
                sp_reg         <= gbm_pkg::SpW'(1);
                visited_reg    <= '0;
                child_ok_reg   <= 1'b0;
                child_fail_reg <= 1'b0;
                root_reg       <= root_reg + 1'b1;
            end
            if (cmd.step)
            begin
                if (child_ok_reg)
                begin
                    owner_valid_reg[top_pos] <= 1'b1;
                    sp_reg <= sp_reg - 1'b1;
                    if (sp_reg == gbm_pkg::SpW'(1))
                        total_reg <= total_reg + 1'b1;
                end
                else if (!found)
                begin
                    sp_reg         <= sp_reg - 1'b1;
                    child_fail_reg <= 1'b1;
                end
                else
                begin
                    visited_reg[found_t] <= 1'b1;
                    if (!owner_valid_reg[found_t])
                    begin
                        owner_valid_reg[found_t] <= 1'b1;
                        sp_reg         <= sp_reg - 1'b1;
                        child_ok_reg   <= 1'b1;
                        child_fail_reg <= 1'b0;
                        if (sp_reg == gbm_pkg::SpW'(1))
                            total_reg <= total_reg + 1'b1;
                    end
                    else if (sp_reg < gbm_pkg::SpW'(Nd))
                    begin
                        sp_reg         <= sp_reg + 1'b1;
                        child_fail_reg <= 1'b0;
                    end
                    else
                        child_fail_reg <= 1'b1;
                end
            end
            if (cmd.emit_next)
                emit_reg <= emit_reg + 1'b1;
        end
    end

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= gbm_pkg::SpW'(Nd))
        else $error("stack overflow");
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= root_reg)
        else $error("more matches than roots");
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(child_ok_reg && child_fail_reg))
        else $error("child both ok and failed");

endmodule

// File: design/gated_bipartite_matcher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_bipartite_matcher_core
// maximum bipartite matching over gated detection-to-track edges
// ----------------------------------------------------------------------------
// Usage:
//   distance entries arrive on in_ch, one transfer per cycle while loading;
//   each stores one edge bit (distance below match_threshold). The entry with
//   last_entry set starts a round: ready drops while a depth-first walk on
//   an explicit stack runs, one search step per cycle. Each detection root
//   is pushed in ST_ROOT and walked in ST_WALK until the stack is empty;
//   ST_ROOT ends the walk once every detection has been tried. Then one
//   result per track leaves on out_ch through an output register, one per
//   cycle while the receiver is ready; a stall simply holds the register.
//   Loading resumes in the cycle after the last result is transferred.
//   match_threshold is written through cfg_we/cfg_data; writing it only
//   while idle is up to the user, as the block has no check for it.
//   Reset: threshold returns to 100, owners and control clear; edge bits
//   are undefined until written.
// ----------------------------------------------------------------------------
module gated_bipartite_matcher_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    gbm_in_if.sink      in_ch,
    gbm_out_if.source   out_ch
);

    logic [15:0] threshold_reg;
    gbm_pkg::gbm_cmd_t cmd;
    gbm_pkg::gbm_sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            threshold_reg <= gbm_pkg::ThresholdReset;
        else if (cfg_we)
            threshold_reg <= cfg_data;
    end

    gbm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_last   (in_ch.data.last_entry),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    gbm_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .match_threshold (threshold_reg),
        .in_data         (in_ch.data),
        .cmd             (cmd),
        .sts             (sts),
        .out_data        (out_ch.data)
    );

endmodule
